[hdl/ced_pkg.sv]
// Shared types, codes and a lookup function for the escape sequence decoder.
package ced_pkg;

    localparam logic [7:0] ESC_CHAR = 8'h5c;
    localparam logic [7:0] HEX_LEAD = 8'h78;
    localparam int unsigned NUM_LANES = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_END       = 2'd1,
        ST_HEX_EMPTY = 2'd2,
        ST_OCT_BIG   = 2'd3
    } t_status;

    // Digit classification of one byte, as found by one lane
    typedef struct packed {
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       oct_ok;
        logic [2:0] oct_val;
    } t_digit;

    // One decoded word, as handed from the merge stage to the output register
    typedef struct packed {
        logic [7:0] value;
        logic [2:0] count;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_simple;

    // Map a simple escape letter to its byte value
    function automatic t_simple simple_escape(input logic [7:0] c);
        t_simple r;
        r.hit   = 1'b1;
        r.value = 8'h00;
        case (c)
            8'h6e: r.value = 8'd10;
            8'h74: r.value = 8'd9;
            8'h76: r.value = 8'd11;
            8'h62: r.value = 8'd8;
            8'h72: r.value = 8'd13;
            8'h66: r.value = 8'd12;
            8'h61: r.value = 8'd7;
            8'h27: r.value = 8'd39;
            8'h22: r.value = 8'd34;
            8'h5c: r.value = 8'd92;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[hdl/ced_lane.sv]
// One digit lane: classifies a single window byte as hex and octal digit.
module ced_lane (
    input  logic [7:0]      i_byte,
    output ced_pkg::t_digit o_digit
);

    logic [7:0] w_lower;

    // fold upper-case letters onto lower case
    assign w_lower = i_byte | 8'h20;

    always_comb begin
        o_digit = '0;
        // hex digit: 0-9, a-f, A-F
        if (i_byte inside {[8'h30:8'h39]}) begin
            o_digit.hex_ok  = 1'b1;
            o_digit.hex_val = i_byte[3:0];
        end else if (w_lower inside {[8'h61:8'h66]} &&
                     (i_byte inside {[8'h41:8'h46], [8'h61:8'h66]})) begin
            o_digit.hex_ok  = 1'b1;
            o_digit.hex_val = w_lower[3:0] + 4'd9;
        end
        // octal digit: 0-7
        if (i_byte inside {[8'h30:8'h37]}) begin
            o_digit.oct_ok  = 1'b1;
            o_digit.oct_val = i_byte[2:0];
        end
    end

endmodule

[hdl/ced_merge.sv]
// Merge stage: combines the lane digit flags with the lead bytes into one result.
module ced_merge (
    input  logic [7:0]      i_byte_first,
    input  logic [7:0]      i_byte_second,
    input  ced_pkg::t_digit i_lane [ced_pkg::NUM_LANES],
    output ced_pkg::t_result o_result
);

    ced_pkg::t_simple w_simple;
    logic [1:0]       w_hex_nd;
    logic [7:0]       w_hex_val;
    logic [1:0]       w_oct_nd;
    logic [8:0]       w_oct_val;

    assign w_simple = ced_pkg::simple_escape(i_byte_second);

    // count leading hex digits after the x (lanes 1..3) and keep the low byte
    always_comb begin
        if (!i_lane[1].hex_ok) begin
            w_hex_nd  = 2'd0;
            w_hex_val = 8'h00;
        end else if (!i_lane[2].hex_ok) begin
            w_hex_nd  = 2'd1;
            w_hex_val = {4'h0, i_lane[1].hex_val};
        end else if (!i_lane[3].hex_ok) begin
            w_hex_nd  = 2'd2;
            w_hex_val = {i_lane[1].hex_val, i_lane[2].hex_val};
        end else begin
            w_hex_nd  = 2'd3;
            w_hex_val = {i_lane[2].hex_val, i_lane[3].hex_val};
        end
    end

    // count leading octal digits after the backslash (lanes 0..2)
    always_comb begin
        if (!i_lane[1].oct_ok) begin
            w_oct_nd  = 2'd1;
            w_oct_val = {6'd0, i_lane[0].oct_val};
        end else if (!i_lane[2].oct_ok) begin
            w_oct_nd  = 2'd2;
            w_oct_val = {3'd0, i_lane[0].oct_val, i_lane[1].oct_val};
        end else begin
            w_oct_nd  = 2'd3;
            w_oct_val = {i_lane[0].oct_val, i_lane[1].oct_val, i_lane[2].oct_val};
        end
    end

    // pick the case by the lead bytes
    always_comb begin
        o_result.value  = 8'h00;
        o_result.count  = 3'd1;
        o_result.status = ced_pkg::ST_OK;
        if (i_byte_first == 8'h00) begin
            o_result.count  = 3'd0;
            o_result.status = ced_pkg::ST_END;
        end else if (i_byte_first != ced_pkg::ESC_CHAR) begin
            o_result.value = i_byte_first;
        end else if (i_byte_second == 8'h00) begin
            o_result.value = ced_pkg::ESC_CHAR;
        end else if (w_simple.hit) begin
            o_result.value = w_simple.value;
            o_result.count = 3'd2;
        end else if (i_byte_second == ced_pkg::HEX_LEAD) begin
            o_result.count = 3'd2 + {1'b0, w_hex_nd};
            if (w_hex_nd == 2'd0) begin
                o_result.status = ced_pkg::ST_HEX_EMPTY;
            end else begin
                o_result.value = w_hex_val;
            end
        end else if (i_lane[0].oct_ok) begin
            o_result.count = 3'd1 + {1'b0, w_oct_nd};
            if (w_oct_val[8]) begin
                o_result.status = ced_pkg::ST_OCT_BIG;
            end else begin
                o_result.value = w_oct_val[7:0];
            end
        end else begin
            o_result.value = i_byte_second;
            o_result.count = 3'd2;
        end
    end

endmodule

[hdl/c_escape_sequence_decoder.sv]
// Top level of the escape sequence decoder: digit lanes, merge and output register.
//
// Usage:
//   Drive a five-byte window from the head of a text buffer on i_byte_first
//   .. i_byte_fifth and raise start. A word is taken at each rising edge
//   where start is high and busy is low; busy is always low, so a new
//   window may be offered in every cycle.
//   Four digit lanes classify bytes two to five in parallel; the merge stage
//   selects the case from the first two bytes and the lane flags.
//   In the cycle after a window is taken, o_valid is high for exactly one cycle
//   with o_decoded_value, o_consumed_count and o_status (0 ok, 1 end of
//   text, 2 hex escape without digits, 3 octal value over 255).
//   Throughput is one window per cycle; the merge logic feeds the single
//   output register.
//   The receiver cannot stall: each result is shown for one cycle only and
//   must be captured then.
//   Synchronous reset (i_rst_n low) clears o_valid; no result is pending
//   after reset.
module c_escape_sequence_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_byte_first,
    input  logic [7:0] i_byte_second,
    input  logic [7:0] i_byte_third,
    input  logic [7:0] i_byte_fourth,
    input  logic [7:0] i_byte_fifth,
    output logic       o_valid,
    output logic [7:0] o_decoded_value,
    output logic [2:0] o_consumed_count,
    output logic [1:0] o_status
);

    logic [7:0]        w_bytes [ced_pkg::NUM_LANES];
    ced_pkg::t_digit   w_lane  [ced_pkg::NUM_LANES];
    ced_pkg::t_result  w_result;
    ced_pkg::t_result  r_result;
    logic              r_valid;

    assign w_bytes[0] = i_byte_second;
    assign w_bytes[1] = i_byte_third;
    assign w_bytes[2] = i_byte_fourth;
    assign w_bytes[3] = i_byte_fifth;

    // classify each trailing byte in its own lane
    for (genvar g = 0; g < ced_pkg::NUM_LANES; g++) begin : g_lane
        ced_lane u_lane (
            .i_byte  (w_bytes[g]),
            .o_digit (w_lane[g])
        );
    end

    // combine lane findings
    ced_merge u_merge (
        .i_byte_first  (i_byte_first),
        .i_byte_second (i_byte_second),
        .i_lane        (w_lane),
        .o_result      (w_result)
    );

    // hold the strobe for one cycle per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
        end
    end

    // capture the decoded word
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_result <= w_result;
        end
    end

    assign busy             = 1'b0;
    assign o_valid          = r_valid;
    assign o_decoded_value  = r_result.value;
    assign o_consumed_count = r_result.count;
    assign o_status         = r_result.status;

endmodule

[hdl/ced_checker.sv]
// Port-level checks for the escape sequence decoder, bound to the top level.
module ced_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_decoded_value,
    input logic [2:0] o_consumed_count,
    input logic [1:0] o_status
);

    // every accepted word yields a result in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted word gave no result");

    // no result without an accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without accepted word");

    // end of text consumes nothing and yields zero
    a_end_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ced_pkg::ST_END) |->
        (o_consumed_count == 3'd0 && o_decoded_value == 8'h00))
        else $error("bad end-of-text result");

    // hex escape without digits consumes two bytes and yields zero
    a_hex_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ced_pkg::ST_HEX_EMPTY) |->
        (o_consumed_count == 3'd2 && o_decoded_value == 8'h00))
        else $error("bad empty hex result");

    // other results consume between one and five bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ced_pkg::ST_END) |->
        (o_consumed_count != 3'd0 && o_consumed_count <= 3'd5))
        else $error("consumed count out of range");

endmodule

bind c_escape_sequence_decoder ced_checker u_ced_checker (.*);
